/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define UEMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition must never be seen outside reset
`define UEMU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

/* design/uemu_pkg.sv */
// ----------------------------------------------------------------------------
// Universal machine execute unit package
// Widths, opcode, request and status codes, and the multiply/divide link types.
// ----------------------------------------------------------------------------
`default_nettype none

package uemu_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [WORD_W-1:0] BYTE_MAX = 32'd255;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // Instruction opcodes
    localparam logic [3:0] OP_CMOV     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_STORE    = 4'd2;
    localparam logic [3:0] OP_ADD      = 4'd3;
    localparam logic [3:0] OP_MUL      = 4'd4;
    localparam logic [3:0] OP_DIV      = 4'd5;
    localparam logic [3:0] OP_NAND     = 4'd6;
    localparam logic [3:0] OP_HALT     = 4'd7;
    localparam logic [3:0] OP_MAP      = 4'd8;
    localparam logic [3:0] OP_UNMAP    = 4'd9;
    localparam logic [3:0] OP_OUT      = 4'd10;
    localparam logic [3:0] OP_IN       = 4'd11;
    localparam logic [3:0] OP_LOADPROG = 4'd12;
    localparam logic [3:0] OP_LOADIMM  = 4'd13;

    // Item kinds
    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_RESP = 1'b1;

    // Request kinds
    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_READ  = 4'd1;
    localparam logic [3:0] KIND_WRITE = 4'd2;
    localparam logic [3:0] KIND_MAP   = 4'd3;
    localparam logic [3:0] KIND_UNMAP = 4'd4;
    localparam logic [3:0] KIND_OUT   = 4'd5;
    localparam logic [3:0] KIND_LOADP = 4'd6;
    localparam logic [3:0] KIND_JUMP  = 4'd7;
    localparam logic [3:0] KIND_HALT  = 4'd8;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DIVZERO  = 2'd1;
    localparam logic [1:0] STAT_OUTRANGE = 2'd2;
    localparam logic [1:0] STAT_HALTED   = 2'd3;

    // Multiply/divide unit command and response
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } md_rsp_t;

endpackage

`default_nettype wire

/* design/uemu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module uemu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/uemu_muldiv.sv */
// ----------------------------------------------------------------------------
// Multiply/divide unit
// Radix-2 shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uemu_muldiv (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire uemu_pkg::md_req_t       req,
    input  wire logic [uemu_pkg::WORD_W-1:0] op_b,
    input  wire logic [uemu_pkg::WORD_W-1:0] op_c,
    output uemu_pkg::md_rsp_t            rsp
);
    import uemu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] x_reg, x_next;     // multiplicand or divisor
    logic [WORD_W-1:0] y_reg, y_next;     // multiplier or quotient
    logic [WORD_W:0]   acc_reg, acc_next; // product or remainder
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    // Remainder shifted by one quotient bit, and trial subtract
    assign shifted = {acc_reg[WORD_W-1:0], y_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, x_reg};

    // Iterate one bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            x_next    = op_c;
            y_next    = op_b;
            acc_next  = '0;
            if (!req.is_div) begin
                x_next = op_b;
                y_next = op_c;
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!diff[WORD_W]) begin
                    acc_next = diff;
                    y_next   = {y_reg[WORD_W-2:0], 1'b1};
                end else begin
                    acc_next = shifted;
                    y_next   = {y_reg[WORD_W-2:0], 1'b0};
                end
            end else begin
                acc_next = acc_reg + {1'b0, (y_reg[0] ? x_reg : '0)};
                x_next   = {x_reg[WORD_W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[WORD_W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = div_reg ? y_reg : acc_reg[WORD_W-1:0];

    `UEMU_ASSERT_NEVER(a_md_start_busy, req.start && busy_reg, "start while busy")
    `UEMU_ASSERT(a_md_done_pulse, done_reg |=> !done_reg, "done held two cycles")

endmodule

`default_nettype wire

/* design/universal_machine_execute_unit_core.sv */
// ----------------------------------------------------------------------------
// Universal machine execute unit
// Register-file execute stage of a 14-opcode, eight-register, 32-bit machine.
// ----------------------------------------------------------------------------
// Input channel (s_*): one decoded instruction or one memory response per
// transfer. Output channel (m_*): exactly one result per input, in order,
// carrying the request kind, status, the three selected registers as they
// stood before the instruction, and the register awaiting a read/map word.
// The register file lives in an 8x32 RAM with one read port, so the three
// operands are fetched one after another: a register-only instruction or a
// memory request steps through RDB, RDC, CAPC, EXEC and DONE, a response
// or an item after halt goes straight to DONE, and multiply, or divide by a
// nonzero divisor, also waits in MDWAIT as the shared multiply/divide unit
// retires one bit per cycle. A new input is taken once the previous result
// sits in the output register, so a stalled receiver costs nothing until a
// second result is ready; the unit then holds that result and takes no
// input. Reset (aresetn low, synchronous) reads all registers as zero through
// per-entry valid bits, clears the halt flag and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module universal_machine_execute_unit_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [3:0]                    s_opcode,
    input  wire logic [uemu_pkg::REG_IDX_W-1:0] s_reg_a,
    input  wire logic [uemu_pkg::REG_IDX_W-1:0] s_reg_b,
    input  wire logic [uemu_pkg::REG_IDX_W-1:0] s_reg_c,
    input  wire logic [24:0]                   s_immediate,
    input  wire logic [7:0]                    s_in_byte,
    input  wire logic                          s_in_eof,
    input  wire logic [uemu_pkg::WORD_W-1:0]   s_response_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [3:0]                         m_request_kind,
    output logic [1:0]                         m_status,
    output logic [uemu_pkg::WORD_W-1:0]        m_value_a,
    output logic [uemu_pkg::WORD_W-1:0]        m_value_b,
    output logic [uemu_pkg::WORD_W-1:0]        m_value_c,
    output logic [uemu_pkg::REG_IDX_W-1:0]     m_dest_register
);
    import uemu_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RDB    = 7'b0000010,
        ST_RDC    = 7'b0000100,
        ST_CAPC   = 7'b0001000,
        ST_EXEC   = 7'b0010000,
        ST_MDWAIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                 halted_reg, halted_next;
    logic [NUM_REGS-1:0]  vld_reg, vld_next;
    logic                 rd_vld_reg;

    logic [3:0]           op_reg, op_next;
    logic [REG_IDX_W-1:0] a_reg, a_next;
    logic [REG_IDX_W-1:0] b_reg, b_next;
    logic [REG_IDX_W-1:0] c_reg, c_next;
    logic [24:0]          imm_reg, imm_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 eof_reg, eof_next;

    logic [WORD_W-1:0]    va_reg, va_next;
    logic [WORD_W-1:0]    vb_reg, vb_next;
    logic [WORD_W-1:0]    vc_reg, vc_next;
    logic [3:0]           kind_reg, kind_next;
    logic [1:0]           stat_reg, stat_next;
    logic [REG_IDX_W-1:0] dest_reg, dest_next;

    logic                 m_valid_reg, m_valid_next;
    logic [3:0]           m_kind_reg, m_kind_next;
    logic [1:0]           m_stat_reg, m_stat_next;
    logic [WORD_W-1:0]    m_va_reg, m_va_next;
    logic [WORD_W-1:0]    m_vb_reg, m_vb_next;
    logic [WORD_W-1:0]    m_vc_reg, m_vc_next;
    logic [REG_IDX_W-1:0] m_dest_reg, m_dest_next;

    logic                 ram_we;
    logic [REG_IDX_W-1:0] ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [REG_IDX_W-1:0] ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    rd_word;

    md_req_t              md_req;
    md_rsp_t              md_rsp;

    // Register file storage
    uemu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiply/divide unit
    uemu_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_b    (vb_reg),
        .op_c    (vc_reg),
        .rsp     (md_rsp)
    );

    // Entries never written since reset read as zero
    assign rd_word = rd_vld_reg ? ram_rdata : '0;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer: write a response, or fetch A, B, C and execute, then hand over to the output register
    always_comb begin
        state_next   = state_reg;
        halted_next  = halted_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        imm_next     = imm_reg;
        byte_next    = byte_reg;
        eof_next     = eof_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        vc_next      = vc_reg;
        kind_next    = kind_reg;
        stat_next    = stat_reg;
        dest_next    = dest_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_stat_next  = m_stat_reg;
        m_va_next    = m_va_reg;
        m_vb_next    = m_vb_reg;
        m_vc_next    = m_vc_reg;
        m_dest_next  = m_dest_reg;
        ram_we       = 1'b0;
        ram_waddr    = a_reg;
        ram_wdata    = '0;
        ram_raddr    = a_reg;
        md_req.start  = 1'b0;
        md_req.is_div = (op_reg == OP_DIV);

        // Drop the output once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                ram_raddr = s_reg_a;
                if (s_valid) begin
                    op_next   = s_opcode;
                    a_next    = s_reg_a;
                    b_next    = s_reg_b;
                    c_next    = s_reg_c;
                    imm_next  = s_immediate;
                    byte_next = s_in_byte;
                    eof_next  = s_in_eof;
                    kind_next = KIND_NONE;
                    stat_next = STAT_OK;
                    dest_next = '0;
                    va_next   = '0;
                    vb_next   = '0;
                    vc_next   = '0;
                    if (halted_reg) begin
                        stat_next  = STAT_HALTED;
                        state_next = ST_DONE;
                    end else if (s_action == ACT_RESP) begin
                        ram_we     = 1'b1;
                        ram_waddr  = s_reg_a;
                        ram_wdata  = s_response_data;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RDB;
                    end
                end
            end
            ST_RDB: begin
                va_next    = rd_word;
                ram_raddr  = b_reg;
                state_next = ST_RDC;
            end
            ST_RDC: begin
                vb_next    = rd_word;
                ram_raddr  = c_reg;
                state_next = ST_CAPC;
            end
            ST_CAPC: begin
                vc_next    = rd_word;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_CMOV: begin
                        ram_we    = (vc_reg != '0);
                        ram_wdata = vb_reg;
                    end
                    OP_LOAD: begin
                        kind_next = KIND_READ;
                        dest_next = a_reg;
                    end
                    OP_STORE: kind_next = KIND_WRITE;
                    OP_ADD: begin
                        ram_we    = 1'b1;
                        ram_wdata = vb_reg + vc_reg;
                    end
                    OP_MUL: begin
                        md_req.start = 1'b1;
                        state_next   = ST_MDWAIT;
                    end
                    OP_DIV: begin
                        if (vc_reg == '0) begin
                            stat_next = STAT_DIVZERO;
                        end else begin
                            md_req.start = 1'b1;
                            state_next   = ST_MDWAIT;
                        end
                    end
                    OP_NAND: begin
                        ram_we    = 1'b1;
                        ram_wdata = ~(vb_reg & vc_reg);
                    end
                    OP_HALT: begin
                        kind_next   = KIND_HALT;
                        halted_next = 1'b1;
                    end
                    OP_MAP: begin
                        kind_next = KIND_MAP;
                        dest_next = b_reg;
                    end
                    OP_UNMAP: kind_next = KIND_UNMAP;
                    OP_OUT: begin
                        if (vc_reg > BYTE_MAX) begin
                            stat_next = STAT_OUTRANGE;
                        end else begin
                            kind_next = KIND_OUT;
                        end
                    end
                    OP_IN: begin
                        ram_we    = 1'b1;
                        ram_waddr = c_reg;
                        ram_wdata = eof_reg ? ALL_ONES : {24'd0, byte_reg};
                    end
                    OP_LOADPROG: kind_next = (vb_reg == '0) ? KIND_JUMP : KIND_LOADP;
                    OP_LOADIMM: begin
                        ram_we    = 1'b1;
                        ram_wdata = {7'd0, imm_reg};
                    end
                    default: ;
                endcase
            end
            ST_MDWAIT: begin
                if (md_rsp.done) begin
                    ram_we     = 1'b1;
                    ram_wdata  = md_rsp.result;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_stat_next  = stat_reg;
                    m_va_next    = va_reg;
                    m_vb_next    = vb_reg;
                    m_vc_next    = vc_reg;
                    m_dest_next  = dest_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Mark written entries valid
        vld_next = vld_reg;
        if (ram_we) begin
            vld_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            halted_reg  <= 1'b0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            halted_reg  <= halted_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
        rd_vld_reg <= vld_reg[ram_raddr];
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        imm_reg    <= imm_next;
        byte_reg   <= byte_next;
        eof_reg    <= eof_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        vc_reg     <= vc_next;
        kind_reg   <= kind_next;
        stat_reg   <= stat_next;
        dest_reg   <= dest_next;
        m_kind_reg <= m_kind_next;
        m_stat_reg <= m_stat_next;
        m_va_reg   <= m_va_next;
        m_vb_reg   <= m_vb_next;
        m_vc_reg   <= m_vc_next;
        m_dest_reg <= m_dest_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_request_kind  = m_kind_reg;
    assign m_status        = m_stat_reg;
    assign m_value_a       = m_va_reg;
    assign m_value_b       = m_vb_reg;
    assign m_value_c       = m_vc_reg;
    assign m_dest_register = m_dest_reg;

    `UEMU_ASSERT(a_halt_sticky, halted_reg |=> halted_reg, "halt flag cleared")
    `UEMU_ASSERT_NEVER(a_no_write_halted, ram_we && halted_reg, "register write after halt")
    `UEMU_ASSERT_NEVER(a_md_done_state, md_rsp.done && (state_reg != ST_MDWAIT),
        "multiply/divide finished outside wait")
    `UEMU_ASSERT(a_done_hold,
        (state_reg == ST_DONE) && m_valid_reg && !m_ready |=> (state_reg == ST_DONE),
        "result left while output register full")

endmodule

`default_nettype wire
